// ===== hw/rtl/pms_pkg.sv =====
// Shared types and constants of the Potts Metropolis step engine.
package pms_pkg;

  localparam int unsigned KIND_W   = 2;
  localparam int unsigned SITE_W   = 4;
  localparam int unsigned BASE_W   = 2;
  localparam int unsigned ENERGY_W = 16;
  localparam int unsigned DRAW_W   = 16;
  localparam int unsigned ITEMP_W  = 16;
  localparam int unsigned CHANGE_W = 21;

  localparam logic [ITEMP_W-1:0] ITEMP_RESET = 16'd1707;

  typedef enum logic [KIND_W-1:0] {
    KIND_FIELD    = 2'd0,
    KIND_COUPLING = 2'd1,
    KIND_CHAIN    = 2'd2,
    KIND_PROPOSE  = 2'd3
  } kind_e;

  // Controller to datapath.
  typedef struct packed {
    logic in_fire;      // input transfer this cycle
    logic read_old;     // chain read at the proposed site
    logic check;        // latch old base, clear sum, read fields, restart walk
    logic issue_chain;  // walk step: chain read at the walk index
    logic sat_load;     // register clamped energy change
    logic mul_load;     // register change * inverse temperature
    logic lut_load;     // register exp table lookup
    logic out_load;     // load result register, commit chain on accept
  } dp_cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic propose_ok;   // input is a proposal with in-range site and base
    logic same;         // proposed base equals current base
    logic walk_last;    // walk index at the last site
  } dp_status_t;

endpackage

// ===== hw/rtl/pms_ctrl.sv =====
// Sequencer of the Potts Metropolis step engine.
module pms_ctrl
  import pms_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output dp_cmd_t    cmd_o,
  input  dp_status_t status_i
);

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_OLD,
    ST_CHECK,
    ST_WALK,
    ST_DRAIN1,
    ST_DRAIN2,
    ST_SAT,
    ST_MUL,
    ST_LUT,
    ST_DEC
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   in_fire;
  logic   slot_free;

  assign in_ready_o  = (state_q == ST_IDLE);
  assign in_fire     = in_valid_i && in_ready_o;
  assign slot_free   = !out_valid_q || out_ready_i;
  assign out_valid_o = out_valid_q;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    cmd_o.in_fire = in_fire;
    case (state_q)
      ST_IDLE: begin
        if (in_fire && status_i.propose_ok) state_d = ST_OLD;
      end
      ST_OLD: begin
        cmd_o.read_old = 1'b1;
        state_d = ST_CHECK;
      end
      ST_CHECK: begin
        cmd_o.check = 1'b1;
        state_d = status_i.same ? ST_DEC : ST_WALK;
      end
      ST_WALK: begin
        cmd_o.issue_chain = 1'b1;
        if (status_i.walk_last) state_d = ST_DRAIN1;
      end
      ST_DRAIN1: state_d = ST_DRAIN2;
      ST_DRAIN2: state_d = ST_SAT;
      ST_SAT: begin
        cmd_o.sat_load = 1'b1;
        state_d = ST_MUL;
      end
      ST_MUL: begin
        cmd_o.mul_load = 1'b1;
        state_d = ST_LUT;
      end
      ST_LUT: begin
        cmd_o.lut_load = 1'b1;
        state_d = ST_DEC;
      end
      ST_DEC: begin
        if (slot_free) begin
          cmd_o.out_load = 1'b1;
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    if (cmd_o.out_load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

// ===== hw/rtl/pms_datapath.sv =====
// Tables, chain memory, energy accumulator and acceptance logic.
module pms_datapath
  import pms_pkg::*;
#(
  parameter int NUM_SITES       = 9,
  parameter int NUM_BASES       = 4,
  parameter int EXP_TABLE_DEPTH = 256
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  dp_cmd_t                    cmd_i,
  output dp_status_t                 status_o,
  input  logic                       cfg_valid_i,
  input  logic [ITEMP_W-1:0]         cfg_data_i,
  input  logic [KIND_W-1:0]          kind_i,
  input  logic [SITE_W-1:0]          site_i,
  input  logic [BASE_W-1:0]          base_i,
  input  logic [SITE_W-1:0]          partner_site_i,
  input  logic [BASE_W-1:0]          partner_base_i,
  input  logic signed [ENERGY_W-1:0] energy_value_i,
  input  logic [DRAW_W-1:0]          uniform_draw_i,
  output logic                       accepted_o,
  output logic                       was_change_o,
  output logic signed [CHANGE_W-1:0] energy_change_o
);

  localparam int NUM_ENTRIES = NUM_SITES * NUM_BASES;
  localparam int FA_W        = $clog2(NUM_ENTRIES);
  localparam int CA_W        = $clog2(NUM_ENTRIES * NUM_ENTRIES);
  localparam int J_W         = $clog2(NUM_SITES);
  localparam int ACC_RAW_W   = 18 + $clog2(NUM_SITES);
  localparam int ACC_W       = (ACC_RAW_W > 22) ? ACC_RAW_W : 22;
  localparam int PROD_W      = (CHANGE_W - 1) + ITEMP_W;
  localparam int IDX_W       = PROD_W - 16;
  // Entries past this depth are zero for every table depth.
  localparam int EXP_LUT_DEPTH = 256;
  localparam int LUT_W         = $clog2(EXP_LUT_DEPTH);

  localparam logic signed [ACC_W-1:0] SAT_HI = ACC_W'(1048575);
  localparam logic signed [ACC_W-1:0] SAT_LO = ACC_W'(-1048576);

  // exp(-i/16) in Q0.16, by repeated rounding multiply in Q0.32.
  function automatic logic [15:0] exp_entry(int n);
    logic [63:0] v;
    logic [63:0] e;
    v = 64'h1_0000_0000;
    for (int i = 0; i < n; i++) begin
      v = (v * 64'd4034748382 + 64'h8000_0000) >> 32;
    end
    e = (v + 64'h8000) >> 16;
    return (e > 64'hFFFF) ? 16'hFFFF : e[15:0];
  endfunction

  logic [15:0] exp_rom [EXP_LUT_DEPTH];
  for (genvar g = 0; g < EXP_LUT_DEPTH; g++) begin : g_exp
    localparam logic [15:0] ENTRY_VAL = exp_entry(g);
    assign exp_rom[g] = ENTRY_VAL;
  end

  // Storage
  logic signed [ENERGY_W-1:0] field_mem [NUM_ENTRIES];
  logic signed [ENERGY_W-1:0] coup_mem  [NUM_ENTRIES * NUM_ENTRIES];
  logic [BASE_W-1:0]          chain_mem [NUM_SITES];

  logic [ITEMP_W-1:0] itemp_q;

  // Latched proposal
  logic [SITE_W-1:0] site_q;
  logic [BASE_W-1:0] base_q;
  logic [BASE_W-1:0] old_q;
  logic [DRAW_W-1:0] draw_q;
  logic              same_q;

  // Walk pipeline
  logic [J_W-1:0] j_q;
  logic [J_W-1:0] j1_q;
  logic           s1_vld_q, s2_vld_q, f_vld_q;
  logic [BASE_W-1:0] chain_rd_q;
  logic signed [ENERGY_W-1:0] f_rd0_q, f_rd1_q, c_rd0_q, c_rd1_q;
  logic signed [ACC_W-1:0] acc_q, acc_d, fterm, cterm;

  // Decision
  logic signed [CHANGE_W-1:0] delta_q;
  logic [PROD_W-1:0]          prod_q;
  logic [15:0]                prob_q;
  logic [IDX_W-1:0]           idx;
  logic                       accept_w;

  // Result register
  logic                       accepted_q, was_change_q;
  logic signed [CHANGE_W-1:0] energy_q;

  logic site_ok, partner_ok;
  logic [BASE_W-1:0] old_base, cj;
  logic [J_W-1:0]    chain_ra, chain_wa;
  logic [BASE_W-1:0] chain_wd;
  logic              chain_we, field_we, coup_we;
  logic [FA_W-1:0]   fa_w, fa0, fa1;
  logic [CA_W-1:0]   ca_w, ca0, ca1;

  assign site_ok    = (32'(site_i) < NUM_SITES) && (32'(base_i) < NUM_BASES);
  assign partner_ok = (32'(partner_site_i) < NUM_SITES) &&
                      (32'(partner_base_i) < NUM_BASES);

  assign status_o.propose_ok = (kind_i == KIND_PROPOSE) && site_ok;
  assign old_base = (32'(chain_rd_q) >= NUM_BASES) ? '0 : chain_rd_q;
  assign cj       = old_base;
  assign status_o.same      = (old_base == base_q);
  assign status_o.walk_last = (j_q == J_W'(NUM_SITES - 1));

  // Addresses
  assign fa_w = FA_W'(32'(site_i) * NUM_BASES + 32'(base_i));
  assign fa0  = FA_W'(32'(site_q) * NUM_BASES + 32'(base_q));
  assign fa1  = FA_W'(32'(site_q) * NUM_BASES + 32'(old_base));
  assign ca_w = CA_W'((32'(partner_site_i) * NUM_BASES + 32'(partner_base_i)) * NUM_ENTRIES
                      + 32'(site_i) * NUM_BASES + 32'(base_i));
  assign ca0  = CA_W'((32'(j1_q) * NUM_BASES + 32'(cj)) * NUM_ENTRIES
                      + 32'(site_q) * NUM_BASES + 32'(base_q));
  assign ca1  = CA_W'((32'(j1_q) * NUM_BASES + 32'(cj)) * NUM_ENTRIES
                      + 32'(site_q) * NUM_BASES + 32'(old_q));

  assign field_we = cmd_i.in_fire && (kind_i == KIND_FIELD) && site_ok;
  assign coup_we  = cmd_i.in_fire && (kind_i == KIND_COUPLING) && site_ok && partner_ok;

  // Chain: loads in idle, commit at the end of an accepted move
  assign chain_we = (cmd_i.in_fire && (kind_i == KIND_CHAIN) && site_ok) ||
                    (cmd_i.out_load && accept_w && !same_q);
  assign chain_wa = cmd_i.in_fire ? J_W'(site_i) : J_W'(site_q);
  assign chain_wd = cmd_i.in_fire ? base_i : base_q;
  assign chain_ra = cmd_i.read_old ? J_W'(site_q) : j_q;

  always_ff @(posedge clk_i) begin
    if (field_we) field_mem[fa_w] <= energy_value_i;
    f_rd0_q <= field_mem[fa0];
    f_rd1_q <= field_mem[fa1];
  end

  always_ff @(posedge clk_i) begin
    if (coup_we) coup_mem[ca_w] <= energy_value_i;
    c_rd0_q <= coup_mem[ca0];
    c_rd1_q <= coup_mem[ca1];
  end

  always_ff @(posedge clk_i) begin
    if (chain_we) chain_mem[chain_wa] <= chain_wd;
    chain_rd_q <= chain_mem[chain_ra];
  end

  // Energy accumulation
  assign fterm = f_vld_q  ? (ACC_W'(f_rd0_q) - ACC_W'(f_rd1_q)) : '0;
  assign cterm = s2_vld_q ? (ACC_W'(c_rd0_q) - ACC_W'(c_rd1_q)) : '0;
  assign acc_d = cmd_i.check ? '0 : (acc_q + fterm + cterm);

  // Acceptance
  assign idx      = prod_q[PROD_W-1:16];
  assign accept_w = same_q || (delta_q <= 0) || (prob_q > draw_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      itemp_q  <= ITEMP_RESET;
      j_q      <= '0;
      s1_vld_q <= 1'b0;
      s2_vld_q <= 1'b0;
      f_vld_q  <= 1'b0;
    end else begin
      if (cfg_valid_i) itemp_q <= cfg_data_i;
      if (cmd_i.check) begin
        j_q <= '0;
      end else if (cmd_i.issue_chain) begin
        j_q <= j_q + 1'b1;
      end
      s1_vld_q <= cmd_i.issue_chain && (32'(j_q) != 32'(site_q));
      s2_vld_q <= s1_vld_q;
      f_vld_q  <= cmd_i.check;
    end
  end

  always_ff @(posedge clk_i) begin
    j1_q  <= j_q;
    acc_q <= acc_d;
    if (cmd_i.in_fire) begin
      site_q <= site_i;
      base_q <= base_i;
      draw_q <= uniform_draw_i;
    end
    if (cmd_i.check) begin
      old_q  <= old_base;
      same_q <= status_o.same;
    end
    if (cmd_i.sat_load) begin
      if (acc_q > SAT_HI) begin
        delta_q <= CHANGE_W'(SAT_HI);
      end else if (acc_q < SAT_LO) begin
        delta_q <= CHANGE_W'(SAT_LO);
      end else begin
        delta_q <= CHANGE_W'(acc_q);
      end
    end
    if (cmd_i.mul_load) prod_q <= PROD_W'(delta_q[CHANGE_W-2:0]) * PROD_W'(itemp_q);
    if (cmd_i.lut_load) begin
      if ((32'(idx) < EXP_TABLE_DEPTH) && (idx[IDX_W-1:LUT_W] == '0)) begin
        prob_q <= exp_rom[idx[LUT_W-1:0]];
      end else begin
        prob_q <= '0;
      end
    end
    if (cmd_i.out_load) begin
      accepted_q   <= accept_w;
      was_change_q <= !same_q;
      energy_q     <= same_q ? '0 : delta_q;
    end
  end

  assign accepted_o      = accepted_q;
  assign was_change_o    = was_change_q;
  assign energy_change_o = energy_q;

endmodule

// ===== hw/rtl/potts_metropolis_step.sv =====
// Potts chain Metropolis step engine: top level.
//
// Usage
//   Input channel (in_valid_i/in_ready_o) carries one item per transfer.
//   Load kinds (field, coupling, chain site) are written at the transfer
//   edge, give no result, and transfer one per cycle while idle.
//   A proposal walks all sites one per cycle: the chain memory gives the
//   partner base and the dual-port coupling memory gives the new and old
//   couplings of that site. A proposal steps through old-base read, check,
//   walk, drain, clamp, multiply, exp lookup and result load, and the next
//   item transfers only once the engine is back in idle. A proposal of the
//   current base goes from the check straight to the result load.
//   Out-of-range proposals are dropped with no result.
//   Output channel (out_valid_o/out_ready_i) is a result register: a stalled
//   receiver holds it, loads still transfer meanwhile, and the next proposal
//   waits in its final step until the register frees.
//   Configuration channel sets inverse temperature, always ready; write
//   only while idle.
//   Reset: inverse temperature returns to 1707, channels empty. Tables and
//   chain are undefined until loaded; the exp table is constant.
module potts_metropolis_step
  import pms_pkg::*;
#(
  parameter int NUM_SITES       = 9,
  parameter int NUM_BASES       = 4,
  parameter int EXP_TABLE_DEPTH = 256
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_valid_i,
  output logic                       cfg_ready_o,
  input  logic [ITEMP_W-1:0]         cfg_data_i,
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  logic [KIND_W-1:0]          kind_i,
  input  logic [SITE_W-1:0]          site_i,
  input  logic [BASE_W-1:0]          base_i,
  input  logic [SITE_W-1:0]          partner_site_i,
  input  logic [BASE_W-1:0]          partner_base_i,
  input  logic signed [ENERGY_W-1:0] energy_value_i,
  input  logic [DRAW_W-1:0]          uniform_draw_i,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output logic                       accepted_o,
  output logic                       was_change_o,
  output logic signed [CHANGE_W-1:0] energy_change_o
);

  dp_cmd_t    cmd;
  dp_status_t status;

  // Register write is registered on the transfer edge and never stalls.
  assign cfg_ready_o = 1'b1;

  pms_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .cmd_o       (cmd),
    .status_i    (status)
  );

  pms_datapath #(
    .NUM_SITES       (NUM_SITES),
    .NUM_BASES       (NUM_BASES),
    .EXP_TABLE_DEPTH (EXP_TABLE_DEPTH)
  ) u_datapath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .status_o        (status),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_data_i      (cfg_data_i),
    .kind_i          (kind_i),
    .site_i          (site_i),
    .base_i          (base_i),
    .partner_site_i  (partner_site_i),
    .partner_base_i  (partner_base_i),
    .energy_value_i  (energy_value_i),
    .uniform_draw_i  (uniform_draw_i),
    .accepted_o      (accepted_o),
    .was_change_o    (was_change_o),
    .energy_change_o (energy_change_o)
  );

endmodule

// ===== hw/rtl/pms_checker.sv =====
// Port-level checks of the Potts Metropolis step engine, bound to the top.
module pms_checker
  import pms_pkg::*;
#(
  parameter int NUM_SITES       = 9,
  parameter int NUM_BASES       = 4
) (
  input logic                       clk_i,
  input logic                       rst_ni,
  input logic                       in_valid_i,
  input logic                       in_ready_o,
  input logic [KIND_W-1:0]          kind_i,
  input logic [SITE_W-1:0]          site_i,
  input logic [BASE_W-1:0]          base_i,
  input logic                       out_valid_o,
  input logic                       out_ready_i,
  input logic                       accepted_o,
  input logic                       was_change_o,
  input logic signed [CHANGE_W-1:0] energy_change_o
);

  logic propose_xfer;
  assign propose_xfer = in_valid_i && in_ready_o && (kind_i == KIND_PROPOSE) &&
                        (32'(site_i) < NUM_SITES) && (32'(base_i) < NUM_BASES);

  // Stalled result holds.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(accepted_o) &&
      $stable(was_change_o) && $stable(energy_change_o))
    else $error("result changed while stalled");

  // Unchanged base: accepted with zero change.
  a_same: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !was_change_o |-> accepted_o && (energy_change_o == '0))
    else $error("unchanged base result malformed");

  // Non-positive change is always accepted.
  a_downhill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && was_change_o && (energy_change_o[CHANGE_W-1] || energy_change_o == '0)
      |-> accepted_o)
    else $error("downhill move rejected");

  // A proposal occupies the engine.
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    propose_xfer |=> !in_ready_o)
    else $error("input taken during proposal");

endmodule

bind potts_metropolis_step pms_checker #(
  .NUM_SITES (NUM_SITES),
  .NUM_BASES (NUM_BASES)
) u_pms_checker (.*);

// ===== verif/potts_metropolis_step_tb.sv =====
// Self-checking testbench of the Potts chain Metropolis step engine.
module potts_metropolis_step_tb;
  import pms_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  // Geometry of the instance under test; the predictor uses the same numbers.
  localparam int SITES     = 9;
  localparam int BASES     = 4;
  localparam int ENTRIES   = SITES * BASES;
  localparam int EXP_DEPTH = 256;

  localparam int CHANGE_MAX = 1048575;
  localparam int CHANGE_MIN = -1048576;

  localparam int CLK_PERIOD      = 10;
  localparam int RESET_CYCLES    = 11;
  // Wait before a register write and at the end, long enough that a dropped
  // proposal has surely drained.
  localparam int DRAIN_CYCLES    = 2 * (SITES + 9);
  // Long receiver hold-off that backs the engine up onto its input.
  localparam int PRESSURE_CYCLES = 300;
  // Cycles with no transfer on any channel before the run is declared hung.
  localparam int STALL_LIMIT     = 4000;
  localparam int SEGMENTS        = 6;
  localparam int SEGMENT_ITEMS   = 120;

  typedef struct packed {
    logic                       accepted;
    logic                       was_change;
    logic signed [CHANGE_W-1:0] energy_change;
  } outcome_t;

  typedef enum logic {ROW_ITEM, ROW_CFG} row_op_e;

  // One row of stimulus. A pinned row carries its own expectation, which
  // then replaces the predicted one.
  typedef struct packed {
    row_op_e                    op;
    logic [ITEMP_W-1:0]         cfg_value;
    kind_e                      kind;
    logic [SITE_W-1:0]          site;
    logic [BASE_W-1:0]          base;
    logic [SITE_W-1:0]          partner_site;
    logic [BASE_W-1:0]          partner_base;
    logic signed [ENERGY_W-1:0] energy_value;
    logic [DRAW_W-1:0]          uniform_draw;
    logic                       pinned;
    logic                       pin_has;
    outcome_t                   pin_outcome;
  } stim_row_t;

  // ---------------------------------------------------------------------
  // Clock, reset and block inputs, all known from time zero.
  // ---------------------------------------------------------------------
  logic                       clk_i          = 1'b0;
  logic                       rst_ni         = 1'b0;
  logic                       cfg_valid_i    = 1'b0;
  logic                       cfg_ready_o;
  logic [ITEMP_W-1:0]         cfg_data_i     = '0;
  logic                       in_valid_i     = 1'b0;
  logic                       in_ready_o;
  logic [KIND_W-1:0]          kind_i         = '0;
  logic [SITE_W-1:0]          site_i         = '0;
  logic [BASE_W-1:0]          base_i         = '0;
  logic [SITE_W-1:0]          partner_site_i = '0;
  logic [BASE_W-1:0]          partner_base_i = '0;
  logic signed [ENERGY_W-1:0] energy_value_i = '0;
  logic [DRAW_W-1:0]          uniform_draw_i = '0;
  logic                       out_valid_o;
  logic                       out_ready_i    = 1'b0;
  logic                       accepted_o;
  logic                       was_change_o;
  logic signed [CHANGE_W-1:0] energy_change_o;

  // Side band that travels with the payload of a pinned row.
  logic     pin_active  = 1'b0;
  logic     pin_has     = 1'b0;
  outcome_t pin_outcome = '0;

  // Idle rates in percent, and the hold-off request to the result sink.
  int unsigned tx_idle_pct  = 6;
  int unsigned rx_idle_pct  = 54;
  bit          hold_request = 1'b0;

  int unsigned error_count = 0;

  // ---------------------------------------------------------------------
  // Predictor state: own copy of the tables, the chain and the register.
  // ---------------------------------------------------------------------
  logic signed [ENERGY_W-1:0] field_tab [ENTRIES];
  logic signed [ENERGY_W-1:0] coup_tab  [ENTRIES*ENTRIES];
  logic [BASE_W-1:0]          chain_tab [SITES];
  logic [15:0]                exp_tab   [EXP_DEPTH];
  logic [ITEMP_W-1:0]         itemp_model = ITEMP_RESET;

  // Outcomes of proposals that yield a result, oldest first.
  outcome_t outcomes_due [$];

  stim_row_t directed [$];

  always #(CLK_PERIOD/2) clk_i = ~clk_i;

  potts_metropolis_step #(
    .NUM_SITES       (SITES),
    .NUM_BASES       (BASES),
    .EXP_TABLE_DEPTH (EXP_DEPTH)
  ) dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_ready_o     (cfg_ready_o),
    .cfg_data_i      (cfg_data_i),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .kind_i          (kind_i),
    .site_i          (site_i),
    .base_i          (base_i),
    .partner_site_i  (partner_site_i),
    .partner_base_i  (partner_base_i),
    .energy_value_i  (energy_value_i),
    .uniform_draw_i  (uniform_draw_i),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .accepted_o      (accepted_o),
    .was_change_o    (was_change_o),
    .energy_change_o (energy_change_o)
  );

  // ---------------------------------------------------------------------
  // Predictor: applies one transferred item to the model state and returns
  // 1 with the outcome when the item is a proposal that yields a result.
  // ---------------------------------------------------------------------
  function automatic bit apply_item(input kind_e k, input logic [SITE_W-1:0] st,
                                    input logic [BASE_W-1:0] bs,
                                    input logic [SITE_W-1:0] ps,
                                    input logic [BASE_W-1:0] pb,
                                    input logic signed [ENERGY_W-1:0] ev,
                                    input logic [DRAW_W-1:0] dr,
                                    output outcome_t res);
    int unsigned      old_b;
    int unsigned      row;
    int               delta;
    longint unsigned  scaled;
    longint unsigned  idx;
    logic [15:0]      prob;
    bit               take;
    res = '0;
    // Any load or proposal naming a site past the chain is ignored.
    if (st >= SITES) return 1'b0;
    case (k)
      KIND_FIELD: begin
        field_tab[st*BASES + bs] = ev;
        return 1'b0;
      end
      KIND_COUPLING: begin
        if (ps < SITES) coup_tab[(BASES*ps + pb)*ENTRIES + BASES*st + bs] = ev;
        return 1'b0;
      end
      KIND_CHAIN: begin
        chain_tab[st] = bs;
        return 1'b0;
      end
      default: ;
    endcase
    old_b = chain_tab[st];
    // Proposal of the base already held: accepted, nothing changes.
    if (old_b == bs) begin
      res.accepted = 1'b1;
      return 1'b1;
    end
    delta = field_tab[st*BASES + bs] - field_tab[st*BASES + old_b];
    for (int j = 0; j < SITES; j++) begin
      if (j != st) begin
        row   = (BASES*j + chain_tab[j]) * ENTRIES + BASES*st;
        delta = delta + (coup_tab[row + bs] - coup_tab[row + old_b]);
      end
    end
    if (delta > CHANGE_MAX) delta = CHANGE_MAX;
    if (delta < CHANGE_MIN) delta = CHANGE_MIN;
    if (delta <= 0) begin
      take = 1'b1;
    end else begin
      // exp(-delta * beta): index is floor(16 * x) of the Q.20 product.
      scaled = longint'(delta) * longint'(itemp_model);
      idx    = scaled >> 16;
      prob   = (idx < EXP_DEPTH) ? exp_tab[idx] : 16'd0;
      take   = prob > dr;
    end
    if (take) chain_tab[st] = bs;
    res.accepted      = take;
    res.was_change    = 1'b1;
    res.energy_change = delta[CHANGE_W-1:0];
    return 1'b1;
  endfunction

  // Sites that proposals and chain writes may touch; the others keep their
  // preloaded base, so only their couplings at that base are ever read.
  function automatic bit movable(input int s);
    return (s < 4) || (s == SITES - 1);
  endfunction

  // ---------------------------------------------------------------------
  // Row builders for the stimulus.
  // ---------------------------------------------------------------------
  function automatic stim_row_t item_row(input kind_e k, input int st, input int bs,
                                         input int ps, input int pb, input int ev,
                                         input int dr);
    stim_row_t r;
    r              = '0;
    r.op           = ROW_ITEM;
    r.kind         = k;
    r.site         = st[SITE_W-1:0];
    r.base         = bs[BASE_W-1:0];
    r.partner_site = ps[SITE_W-1:0];
    r.partner_base = pb[BASE_W-1:0];
    r.energy_value = ev[ENERGY_W-1:0];
    r.uniform_draw = dr[DRAW_W-1:0];
    return r;
  endfunction

  // Typed-in expectation; energy change is always zero where one is pinned.
  function automatic stim_row_t pinned(input stim_row_t r, input bit has,
                                       input bit acc, input bit chg);
    r.pinned      = 1'b1;
    r.pin_has     = has;
    r.pin_outcome = '{accepted: acc, was_change: chg, energy_change: '0};
    return r;
  endfunction

  function automatic stim_row_t cfg_row(input int value);
    stim_row_t r;
    r           = '0;
    r.op        = ROW_CFG;
    r.cfg_value = value[ITEMP_W-1:0];
    return r;
  endfunction

  // ---------------------------------------------------------------------
  // Input driver: payload changes at the falling edge, transfer is seen at
  // the rising edge. Valid stays high between back-to-back items.
  // ---------------------------------------------------------------------
  task automatic send_item(input stim_row_t r);
    @(negedge clk_i);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i     <= 1'b1;
    kind_i         <= r.kind;
    site_i         <= r.site;
    base_i         <= r.base;
    partner_site_i <= r.partner_site;
    partner_base_i <= r.partner_base;
    energy_value_i <= r.energy_value;
    uniform_draw_i <= r.uniform_draw;
    pin_active     <= r.pinned;
    pin_has        <= r.pin_has;
    pin_outcome    <= r.pin_outcome;
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  // Drop valid, wait for every outstanding result, then let a possibly
  // dropped proposal run out of the pipeline.
  task automatic wait_until_idle();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (outcomes_due.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic set_inverse_temperature(input logic [ITEMP_W-1:0] value);
    wait_until_idle();
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  // ---------------------------------------------------------------------
  // Monitor: checks results against the oldest expectation, tracks register
  // writes and feeds every input transfer to the predictor, in that order.
  // ---------------------------------------------------------------------
  always @(posedge clk_i) begin : monitor
    outcome_t got;
    outcome_t want;
    outcome_t pred;
    bit       has;
    if (rst_ni && out_valid_o && out_ready_i) begin
      got = '{accepted: accepted_o, was_change: was_change_o,
              energy_change: energy_change_o};
      if (outcomes_due.size() == 0) begin
        $error("result transfer with no proposal outstanding");
        error_count++;
      end else begin
        want = outcomes_due.pop_front();
        if (got.accepted !== want.accepted) begin
          $error("accepted: expected %0b, actual %0b", want.accepted, got.accepted);
          error_count++;
        end
        if (got.was_change !== want.was_change) begin
          $error("was_change: expected %0b, actual %0b", want.was_change,
                 got.was_change);
          error_count++;
        end
        if (got.energy_change !== want.energy_change) begin
          $error("energy_change: expected %0d, actual %0d", want.energy_change,
                 got.energy_change);
          error_count++;
        end
      end
    end
    if (rst_ni && cfg_valid_i && cfg_ready_o) itemp_model = cfg_data_i;
    if (rst_ni && in_valid_i && in_ready_o) begin
      has = apply_item(kind_e'(kind_i), site_i, base_i, partner_site_i,
                       partner_base_i, energy_value_i, uniform_draw_i, pred);
      if (pin_active) begin
        has  = pin_has;
        pred = pin_outcome;
      end
      if (has) outcomes_due.push_back(pred);
    end
  end

  // ---------------------------------------------------------------------
  // Result sink: random stalls, plus one long hold-off on request, counted
  // here so the sender keeps offering items meanwhile.
  // ---------------------------------------------------------------------
  initial begin : result_sink
    int unsigned hold_left;
    hold_left = 0;
    forever begin
      @(negedge clk_i);
      if (hold_request) begin
        hold_request = 1'b0;
        hold_left    = PRESSURE_CYCLES;
      end
      if (hold_left != 0) begin
        hold_left--;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= ($urandom_range(99) >= rx_idle_pct);
      end
    end
  end

  // Watchdog: a run with no transfer on any channel for too long is hung.
  initial begin : watchdog
    int unsigned quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk_i);
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) ||
          (cfg_valid_i && cfg_ready_o)) quiet = 0;
      else quiet++;
    end
    $display("TB_ERROR");
    $finish;
  end

  // ---------------------------------------------------------------------
  // Main sequence.
  // ---------------------------------------------------------------------
  initial begin : main_seq
    longint unsigned v;
    longint unsigned e;
    stim_row_t       r;
    kind_e           k;
    int              ev;
    int              st;
    int              ps;
    int              pick;
    int              chain_init [SITES];
    logic [ITEMP_W-1:0] itemp_next;

    // Constant exp(-i/16) table, Q0.16, built by repeated Q0.32 steps.
    v = 64'd1 << 32;
    for (int i = 0; i < EXP_DEPTH; i++) begin
      e          = (v + 64'h8000) >> 16;
      exp_tab[i] = (e > 64'd65535) ? 16'hFFFF : e[15:0];
      v          = (v * 64'd4034748382 + 64'h8000_0000) >> 32;
    end
    foreach (chain_init[s]) chain_init[s] = $urandom_range(3);

    repeat (RESET_CYCLES) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Preload: every entry that a proposal can read gets written first.
    // Proposals and chain writes stay on the movable sites, so couplings of
    // the other sites are needed only at their preloaded base. Values are
    // kept small so deltas land in the part of the exp table where the draw
    // decides.
    for (int s = 0; s < SITES; s++)
      for (int b = 0; b < BASES; b++)
        send_item(item_row(KIND_FIELD, s, b, $urandom_range(15), $urandom_range(3),
                           int'($urandom_range(2047)) - 1024, $urandom_range(65535)));
    for (int y = 0; y < SITES; y++)
      for (int yb = 0; yb < BASES; yb++)
        for (int x = 0; x < SITES; x++)
          for (int xb = 0; xb < BASES; xb++)
            if (x != y && movable(x) && (movable(y) || yb == chain_init[y]))
              send_item(item_row(KIND_COUPLING, x, xb, y, yb,
                                 int'($urandom_range(255)) - 128, $urandom_range(65535)));
    for (int s = 0; s < SITES; s++)
      send_item(item_row(KIND_CHAIN, s, chain_init[s], $urandom_range(15),
                         $urandom_range(3), int'($urandom_range(65535)),
                         $urandom_range(65535)));

    // Directed rows: unchanged base, dropped out-of-range items, field and
    // coupling extremes, and the acceptance test at zero, full-scale, unit
    // and reset inverse temperature.
    directed.push_back(item_row(KIND_CHAIN, 0, 2, 0, 0, 0, 0));
    directed.push_back(pinned(item_row(KIND_PROPOSE, 0, 2, 0, 0, 0, 0), 1, 1, 0));
    directed.push_back(pinned(item_row(KIND_PROPOSE, 9, 1, 0, 0, 0, 12345), 0, 0, 0));
    directed.push_back(pinned(item_row(KIND_PROPOSE, 15, 3, 15, 3, -1, 65535), 0, 0, 0));
    directed.push_back(pinned(item_row(KIND_FIELD, 9, 0, 0, 0, 32767, 0), 0, 0, 0));
    directed.push_back(pinned(item_row(KIND_COUPLING, 0, 0, 12, 3, -32768, 0), 0, 0, 0));
    directed.push_back(pinned(item_row(KIND_CHAIN, 15, 1, 0, 0, 0, 0), 0, 0, 0));
    directed.push_back(item_row(KIND_FIELD, 1, 0, 0, 0, -32768, 0));
    directed.push_back(item_row(KIND_FIELD, 1, 1, 0, 0, 32767, 0));
    directed.push_back(item_row(KIND_CHAIN, 1, 0, 0, 0, 0, 0));
    directed.push_back(item_row(KIND_PROPOSE, 1, 1, 0, 0, 0, 0));
    directed.push_back(cfg_row(0));
    directed.push_back(item_row(KIND_PROPOSE, 1, 1, 0, 0, 0, 65535));
    directed.push_back(item_row(KIND_PROPOSE, 1, 1, 0, 0, 0, 65534));
    directed.push_back(item_row(KIND_PROPOSE, 1, 0, 0, 0, 0, 65535));
    directed.push_back(cfg_row(65535));
    directed.push_back(item_row(KIND_PROPOSE, 1, 1, 0, 0, 0, 0));
    directed.push_back(item_row(KIND_COUPLING, 8, 3, 0, 2, 32767, 0));
    directed.push_back(item_row(KIND_COUPLING, 8, 2, 0, 2, -32768, 0));
    directed.push_back(cfg_row(1));
    directed.push_back(item_row(KIND_PROPOSE, 8, 3, 0, 0, 0, 0));
    directed.push_back(item_row(KIND_PROPOSE, 8, 2, 0, 0, 0, 65535));
    directed.push_back(cfg_row(ITEMP_RESET));

    foreach (directed[i]) begin
      if (directed[i].op == ROW_CFG) set_inverse_temperature(directed[i].cfg_value);
      else send_item(directed[i]);
    end

    // Random part: two segments per idle mode, a new temperature each.
    for (int seg = 0; seg < SEGMENTS; seg++) begin
      case (seg / 2)
        0:       begin tx_idle_pct = 6;  rx_idle_pct = 54; end
        1:       begin tx_idle_pct = 54; rx_idle_pct = 6;  end
        default: begin tx_idle_pct = 0;  rx_idle_pct = 0;  end
      endcase
      case (seg)
        0:       itemp_next = ITEMP_W'($urandom_range(4096, 256));
        1:       itemp_next = ITEMP_W'($urandom_range(65535));
        2:       itemp_next = ITEMP_W'($urandom_range(1024, 64));
        3:       itemp_next = ITEMP_W'($urandom_range(8192, 1024));
        4:       itemp_next = ITEMP_W'($urandom_range(2048));
        default: itemp_next = ITEMP_W'($urandom_range(65535));
      endcase
      set_inverse_temperature(itemp_next);
      // Receiver goes quiet for a long stretch while items keep coming.
      if (seg == 4) hold_request = 1'b1;
      for (int n = 0; n < SEGMENT_ITEMS; n++) begin
        pick = $urandom_range(99);
        if (pick < 50)      k = KIND_PROPOSE;
        else if (pick < 70) k = KIND_FIELD;
        else if (pick < 88) k = KIND_COUPLING;
        else                k = KIND_CHAIN;
        // Mostly small energies, now and then the full 16-bit range.
        ev = ($urandom_range(9) == 0) ? int'($urandom_range(65535))
                                      : int'($urandom_range(2047)) - 1024;
        // Proposals and chain writes only on movable sites.
        if ($urandom_range(19) == 0) begin
          st = $urandom_range(15, 9);
        end else if (k == KIND_PROPOSE || k == KIND_CHAIN) begin
          st = $urandom_range(4);
          if (st == 4) st = SITES - 1;
        end else begin
          st = $urandom_range(8);
        end
        ps = ($urandom_range(19) == 0) ? $urandom_range(15, 9) : $urandom_range(8);
        r  = item_row(k, st, $urandom_range(3), ps, $urandom_range(3), ev,
                      $urandom_range(65535));
        send_item(r);
      end
    end

    wait_until_idle();
    if (error_count == 0) $display("TB_OK");
    else $display("TB_ERROR");
    $finish;
  end

endmodule
